>>> rtl/sorted_keyed_accumulator_table_macros.svh
// assertion helpers for the sorted keyed accumulator table
`ifndef SORTED_KEYED_ACCUMULATOR_TABLE_MACROS_SVH
`define SORTED_KEYED_ACCUMULATOR_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SKAT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("skat assertion failed");

// next-cycle implication
`define SKAT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("skat assertion failed");

`else

`define SKAT_ASSERT_SAME(label, clk, rstn, ante, cons)
`define SKAT_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/skat_pkg.sv
package skat_pkg;

    localparam int KEY_W   = 8;
    localparam int DELTA_W = 32;
    localparam int AMT_W   = 31;
    localparam int TOTAL_W = 40;
    localparam int RANK_W  = 5;
    localparam int COUNT_W = 5;

    localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W - 1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W - 1){1'b0}}};

    typedef struct packed {
        logic [KEY_W-1:0]          resource_id;
        logic signed [DELTA_W-1:0] delta_amount;
    } req_t;

    typedef struct packed {
        logic [AMT_W-1:0]          amount_after;
        logic                      key_present;
        logic [RANK_W-1:0]         key_rank;
        logic [COUNT_W-1:0]        entry_count;
        logic [KEY_W-1:0]          largest_key;
        logic signed [TOTAL_W-1:0] running_total;
        logic                      table_full_drop;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_CMP,
        ST_MOVE
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_UPDATE,
        ACT_REMOVE,
        ACT_INSERT,
        ACT_DROP
    } act_t;

    typedef struct packed {
        logic capture;
        logic calc;
        logic cmp;
        logic move;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

>>> rtl/sorted_keyed_accumulator_table.sv
// channel   direction  handshake         payload
// s_        in         s_valid/s_ready   skat_pkg::req_t  (resource_id, delta_amount)
// m_        out        m_valid/m_ready   skat_pkg::rsp_t  (one result per request)
//
// a request passes through key match across the cell row at accept, add and
// decide, per-cell amount compare, then shift-and-place of the whole row
// the placement step waits while the previous result is still not taken
// reset clears the entry count, the running total and the result valid;
// cell contents are left as they are and gated by the count, so no clearing pass
// requests are refused from accept until placement completes

`include "sorted_keyed_accumulator_table_macros.svh"

module sorted_keyed_accumulator_table #(
    parameter int ENTRIES = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  skat_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output skat_pkg::rsp_t  m_data
);

    // command and status between sequencer and datapath
    skat_pkg::cmd_t    cmd;
    skat_pkg::status_t status;

    // sequencer: accept, decide, compare, place
    skat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // cell row, adder, saturation and result register
    skat_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // a request is in progress right after it is taken
    `SKAT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a dropped key never shows up as present
    `SKAT_ASSERT_SAME(a_drop_absent, aclk, aresetn, m_valid && m_data.table_full_drop, !m_data.key_present)

    // held entries always carry a positive amount
    `SKAT_ASSERT_SAME(a_present_nonzero, aclk, aresetn, m_valid && m_data.key_present, m_data.amount_after != '0)

    // a result appears only from a placement step
    `SKAT_ASSERT_SAME(a_result_from_move, aclk, aresetn, $rose(m_valid), $past(cmd.move))

endmodule

>>> rtl/skat_ctrl.sv
module skat_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  skat_pkg::status_t  status,
    output skat_pkg::cmd_t     cmd
);

    skat_pkg::state_t state_reg;
    skat_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skat_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            skat_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = skat_pkg::ST_CALC;
                end
            end
            skat_pkg::ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = skat_pkg::ST_CMP;
            end
            skat_pkg::ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = skat_pkg::ST_MOVE;
            end
            skat_pkg::ST_MOVE: begin
                // hold until the result register can take the new result
                if (status.out_free) begin
                    cmd.move   = 1'b1;
                    state_next = skat_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = skat_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/skat_datapath.sv
module skat_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  skat_pkg::req_t     s_data,
    input  skat_pkg::cmd_t     cmd,
    output skat_pkg::status_t  status,
    input  logic               m_ready,
    output logic               m_valid,
    output skat_pkg::rsp_t     m_data
);

    localparam int KEY_W   = skat_pkg::KEY_W;
    localparam int AMT_W   = skat_pkg::AMT_W;
    localparam int DELTA_W = skat_pkg::DELTA_W;
    localparam int TOTAL_W = skat_pkg::TOTAL_W;
    localparam int RANK_W  = skat_pkg::RANK_W;
    localparam int COUNT_W = skat_pkg::COUNT_W;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0]  CNT_FULL    = CNT_W'(ENTRIES);
    localparam logic [RANK_W-1:0] RANK_ABSENT = RANK_W'(ENTRIES);

    // cell row
    logic [KEY_W-1:0] cell_key_reg  [ENTRIES];
    logic [AMT_W-1:0] cell_amt_reg  [ENTRIES];
    logic [KEY_W-1:0] cell_key_next [ENTRIES];
    logic [AMT_W-1:0] cell_amt_next [ENTRIES];
    logic [ENTRIES-1:0] cell_valid;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [TOTAL_W-1:0] total_next;

    // request in flight
    logic [KEY_W-1:0]          req_key_reg;
    logic signed [DELTA_W-1:0] req_delta_reg;
    logic [ENTRIES-1:0]        hit_reg;
    logic [ENTRIES-1:0]        hit_next;

    // decision
    skat_pkg::act_t   act_reg;
    skat_pkg::act_t   act_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [AMT_W-1:0] val_reg;
    logic [AMT_W-1:0] val_next;

    // precede flags, one per cell
    logic [ENTRIES-1:0] prec_reg;
    logic [ENTRIES-1:0] prec_next;

    logic m_valid_reg;
    skat_pkg::rsp_t rsp_reg;
    skat_pkg::rsp_t rsp_next;

    logic [IDX_W-1:0]          hit_idx;
    logic [AMT_W-1:0]          old_amt;
    logic signed [AMT_W+1:0]   upd_sum;
    logic signed [TOTAL_W:0]   tot_sum;
    logic signed [TOTAL_W-1:0] tot_sat;

    logic [KEY_W-1:0]   b_key [ENTRIES];
    logic [AMT_W-1:0]   b_amt [ENTRIES];
    logic [ENTRIES-1:0] b_prec;
    logic [ENTRIES-1:0] land;
    logic [IDX_W-1:0]   rank;
    logic               placed;
    logic               reshape;

    assign placed  = (act_reg == skat_pkg::ACT_UPDATE) || (act_reg == skat_pkg::ACT_INSERT);
    assign reshape = (act_reg == skat_pkg::ACT_UPDATE) || (act_reg == skat_pkg::ACT_REMOVE);

    // per-cell match, compare and shift
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        localparam int NXT = (k + 1 < ENTRIES) ? k + 1 : k;
        localparam int PRV = (k > 0) ? k - 1 : 0;
        logic shift_up;
        logic first_free;

        assign cell_valid[k] = CNT_W'(k) < count_reg;
        assign hit_next[k]   = cell_valid[k] && (cell_key_reg[k] == s_data.resource_id);

        // lower positions keep ties ahead, higher positions only if strictly larger
        assign prec_next[k] = cell_valid[k] && (IDX_W'(k) != pos_reg) &&
                              ((IDX_W'(k) < pos_reg) ? (cell_amt_reg[k] >= val_reg)
                                                     : (cell_amt_reg[k] > val_reg));

        // table with the touched entry taken out
        assign shift_up  = reshape && (IDX_W'(k) >= pos_reg);
        assign b_key[k]  = shift_up ? cell_key_reg[NXT] : cell_key_reg[k];
        assign b_amt[k]  = shift_up ? cell_amt_reg[NXT] : cell_amt_reg[k];
        assign b_prec[k] = shift_up ? ((k + 1 < ENTRIES) ? prec_reg[NXT] : 1'b0) : prec_reg[k];

        assign first_free = (k == 0) ? 1'b1 : b_prec[PRV];
        assign land[k]    = placed && !b_prec[k] && first_free;

        assign cell_key_next[k] =
            (act_reg == skat_pkg::ACT_REMOVE) ? b_key[k] :
            !placed                           ? cell_key_reg[k] :
            b_prec[k]                         ? b_key[k] :
            first_free                        ? req_key_reg : b_key[PRV];
        assign cell_amt_next[k] =
            (act_reg == skat_pkg::ACT_REMOVE) ? b_amt[k] :
            !placed                           ? cell_amt_reg[k] :
            b_prec[k]                         ? b_amt[k] :
            first_free                        ? val_reg : b_amt[PRV];
    end

    // decision: locate the key, add, saturate, choose the action
    always_comb begin
        hit_idx = '0;
        old_amt = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            if (hit_reg[j]) begin
                hit_idx |= IDX_W'(j);
                old_amt |= cell_amt_reg[j];
            end
        end
        upd_sum = $signed({2'b00, old_amt}) + $signed({req_delta_reg[DELTA_W-1], req_delta_reg});

        act_next = skat_pkg::ACT_NONE;
        pos_next = hit_idx;
        val_next = old_amt;
        if (|hit_reg) begin
            if (upd_sum <= 0) begin
                act_next = skat_pkg::ACT_REMOVE;
            end else begin
                act_next = skat_pkg::ACT_UPDATE;
                if (upd_sum > $signed({2'b00, skat_pkg::AMT_MAX})) begin
                    val_next = skat_pkg::AMT_MAX;
                end else begin
                    val_next = upd_sum[AMT_W-1:0];
                end
            end
        end else if (req_delta_reg > 0) begin
            if (count_reg < CNT_FULL) begin
                act_next = skat_pkg::ACT_INSERT;
                pos_next = count_reg[IDX_W-1:0];
                val_next = req_delta_reg[AMT_W-1:0];
            end else begin
                act_next = skat_pkg::ACT_DROP;
            end
        end

        tot_sum = $signed({total_reg[TOTAL_W-1], total_reg}) +
                  $signed({{(TOTAL_W + 1 - DELTA_W){req_delta_reg[DELTA_W-1]}}, req_delta_reg});
        if (tot_sum[TOTAL_W] != tot_sum[TOTAL_W-1]) begin
            tot_sat = tot_sum[TOTAL_W] ? skat_pkg::TOTAL_MIN : skat_pkg::TOTAL_MAX;
        end else begin
            tot_sat = tot_sum[TOTAL_W-1:0];
        end
        total_next = (act_next == skat_pkg::ACT_DROP) ? total_reg : tot_sat;
    end

    // result assembly
    always_comb begin
        rank = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            if (land[j]) begin
                rank |= IDX_W'(j);
            end
        end
        count_next = count_reg;
        case (act_reg)
            skat_pkg::ACT_REMOVE: count_next = count_reg - 1'b1;
            skat_pkg::ACT_INSERT: count_next = count_reg + 1'b1;
            default:              count_next = count_reg;
        endcase

        rsp_next.amount_after    = placed ? val_reg : '0;
        rsp_next.key_present     = placed;
        rsp_next.key_rank        = placed ? RANK_W'(rank) : RANK_ABSENT;
        rsp_next.entry_count     = COUNT_W'(count_next);
        rsp_next.largest_key     = (count_next != '0) ? cell_key_next[0] : '0;
        rsp_next.running_total   = total_reg;
        rsp_next.table_full_drop = (act_reg == skat_pkg::ACT_DROP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.calc) begin
                total_reg <= total_next;
            end
            if (cmd.move) begin
                count_reg <= count_next;
            end
            if (cmd.move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_key_reg   <= s_data.resource_id;
            req_delta_reg <= s_data.delta_amount;
            hit_reg       <= hit_next;
        end
        if (cmd.calc) begin
            act_reg <= act_next;
            pos_reg <= pos_next;
            val_reg <= val_next;
        end
        if (cmd.cmp) begin
            prec_reg <= prec_next;
        end
        if (cmd.move) begin
            rsp_reg <= rsp_next;
            for (int j = 0; j < ENTRIES; j++) begin
                cell_key_reg[j] <= cell_key_next[j];
                cell_amt_reg[j] <= cell_amt_next[j];
            end
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

>>> test/sorted_keyed_accumulator_table_tb.sv
`timescale 1ns / 1ps

module sorted_keyed_accumulator_table_tb;

    localparam int TABLE_DEPTH      = 16;
    localparam int LONG_HOLD_CYCLES = 300;

    localparam int KEY_W   = skat_pkg::KEY_W;
    localparam int DELTA_W = skat_pkg::DELTA_W;
    localparam int AMT_W   = skat_pkg::AMT_W;
    localparam int TOTAL_W = skat_pkg::TOTAL_W;
    localparam int RANK_W  = skat_pkg::RANK_W;
    localparam int COUNT_W = skat_pkg::COUNT_W;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    skat_pkg::req_t s_data;
    logic m_valid;
    logic m_ready;
    skat_pkg::rsp_t m_data;

    sorted_keyed_accumulator_table #(
        .ENTRIES(TABLE_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // shadow copy of the table, kept in descending amount order
    logic [KEY_W-1:0]          tbl_keys    [TABLE_DEPTH];
    logic [AMT_W-1:0]          tbl_amounts [TABLE_DEPTH];
    int                        tbl_used;
    logic signed [TOTAL_W-1:0] tbl_total;

    // table snapshots predicted per accepted request, oldest first
    skat_pkg::rsp_t predicted_snapshots[$];

    int mismatch_count;
    int requests_sent;
    int results_checked;
    int drops_seen;
    bit hit_total_max;
    bit hit_total_min;

    // sender pacing and receiver hold-off control
    int burst_left;
    bit no_idle;
    bit long_hold_req;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int locate_key(input logic [KEY_W-1:0] key);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_keys[i] == key)
                return i;
        return TABLE_DEPTH;
    endfunction

    // stable insertion sort: an entry only passes strictly smaller amounts
    function automatic void reorder_table();
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amt;
        int j;
        for (int i = 1; i < tbl_used; i++) begin
            key = tbl_keys[i];
            amt = tbl_amounts[i];
            j = i;
            while (j > 0 && tbl_amounts[j-1] < amt) begin
                tbl_keys[j]    = tbl_keys[j-1];
                tbl_amounts[j] = tbl_amounts[j-1];
                j--;
            end
            tbl_keys[j]    = key;
            tbl_amounts[j] = amt;
        end
    endfunction

    // applies one adjustment to the shadow table and returns the snapshot after it
    function automatic skat_pkg::rsp_t apply_adjustment(input skat_pkg::req_t req);
        longint delta;
        longint sum;
        int pos;
        bit dropped;
        skat_pkg::rsp_t snap;
        delta   = longint'(req.delta_amount);
        dropped = 1'b0;
        pos     = locate_key(req.resource_id);
        if (pos < TABLE_DEPTH) begin
            sum = longint'(tbl_amounts[pos]) + delta;
            if (sum <= 0) begin
                // entry leaves, later ones move up one place
                for (int j = pos; j + 1 < tbl_used; j++) begin
                    tbl_keys[j]    = tbl_keys[j+1];
                    tbl_amounts[j] = tbl_amounts[j+1];
                end
                tbl_used--;
            end else begin
                if (sum > longint'(skat_pkg::AMT_MAX))
                    sum = longint'(skat_pkg::AMT_MAX);
                tbl_amounts[pos] = sum[AMT_W-1:0];
                reorder_table();
            end
        end else if (delta > 0) begin
            if (tbl_used < TABLE_DEPTH) begin
                tbl_keys[tbl_used]    = req.resource_id;
                tbl_amounts[tbl_used] = delta[AMT_W-1:0];
                tbl_used++;
                reorder_table();
            end else begin
                dropped = 1'b1;
            end
        end
        // a refused key leaves the total alone
        if (!dropped) begin
            sum = longint'(tbl_total) + delta;
            if (sum > longint'(skat_pkg::TOTAL_MAX))
                sum = longint'(skat_pkg::TOTAL_MAX);
            if (sum < longint'(skat_pkg::TOTAL_MIN))
                sum = longint'(skat_pkg::TOTAL_MIN);
            tbl_total = sum[TOTAL_W-1:0];
        end
        pos = locate_key(req.resource_id);
        snap.amount_after    = (pos < TABLE_DEPTH) ? tbl_amounts[pos] : '0;
        snap.key_present     = (pos < TABLE_DEPTH);
        snap.key_rank        = RANK_W'(pos);
        snap.entry_count     = COUNT_W'(tbl_used);
        snap.largest_key     = (tbl_used > 0) ? tbl_keys[0] : '0;
        snap.running_total   = tbl_total;
        snap.table_full_drop = dropped;
        return snap;
    endfunction

    // mostly a small key pool so the table fills, ties form and entries leave
    function automatic skat_pkg::req_t random_request();
        skat_pkg::req_t req;
        int slot;
        req.resource_id = ($urandom_range(0, 9) < 7) ? KEY_W'($urandom_range(0, 23))
                                                     : KEY_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: req.delta_amount = DELTA_W'($urandom_range(1, 64));
            4:          req.delta_amount = DELTA_W'(-int'($urandom_range(1, 64)));
            5: begin
                // take a held key exactly down to zero
                if (tbl_used > 0) begin
                    slot = $urandom_range(0, tbl_used - 1);
                    req.resource_id  = tbl_keys[slot];
                    req.delta_amount = -$signed({1'b0, tbl_amounts[slot]});
                end else begin
                    req.delta_amount = DELTA_W'($urandom_range(1, 64));
                end
            end
            6:          req.delta_amount = DELTA_W'($urandom);
            7:          req.delta_amount = DELTA_W'(-int'($urandom_range(1, 1 << 24)));
            8: begin
                case ($urandom_range(0, 4))
                    0:       req.delta_amount = '0;
                    1:       req.delta_amount = 32'h7FFF_FFFF;
                    2:       req.delta_amount = 32'h8000_0000;
                    3:       req.delta_amount = 32'h0000_0001;
                    default: req.delta_amount = 32'hFFFF_FFFF;
                endcase
            end
            default:    req.delta_amount = DELTA_W'($urandom_range(1, 1 << 24));
        endcase
        return req;
    endfunction

    // one request; valid stays up into the next call unless a gap is drawn
    task automatic send_request(input logic [KEY_W-1:0] key, input logic [DELTA_W-1:0] delta);
        skat_pkg::req_t req;
        skat_pkg::rsp_t snap;
        int gap;
        req.resource_id  = key;
        req.delta_amount = delta;
        if (!no_idle && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        snap = apply_adjustment(req);
        predicted_snapshots = {predicted_snapshots, snap};
        requests_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (predicted_snapshots.size() != 0)
            @(posedge aclk);
    endtask

    // result side: check each taken result, then pick the next ready level
    initial begin : result_checker
        int hold_left;
        int mode;
        int mode_left;
        skat_pkg::rsp_t want;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (predicted_snapshots.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = predicted_snapshots.pop_front();
                    results_checked++;
                    if (want.table_full_drop)
                        drops_seen++;
                    if (want.running_total == skat_pkg::TOTAL_MAX)
                        hit_total_max = 1'b1;
                    if (want.running_total == skat_pkg::TOTAL_MIN)
                        hit_total_min = 1'b1;
                    if (m_data.amount_after !== want.amount_after) begin
                        $error("amount_after: expected %0d, got %0d",
                               want.amount_after, m_data.amount_after);
                        mismatch_count++;
                    end
                    if (m_data.key_present !== want.key_present) begin
                        $error("key_present: expected %0d, got %0d",
                               want.key_present, m_data.key_present);
                        mismatch_count++;
                    end
                    if (m_data.key_rank !== want.key_rank) begin
                        $error("key_rank: expected %0d, got %0d",
                               want.key_rank, m_data.key_rank);
                        mismatch_count++;
                    end
                    if (m_data.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_data.entry_count);
                        mismatch_count++;
                    end
                    if (m_data.largest_key !== want.largest_key) begin
                        $error("largest_key: expected %0d, got %0d",
                               want.largest_key, m_data.largest_key);
                        mismatch_count++;
                    end
                    if (m_data.running_total !== want.running_total) begin
                        $error("running_total: expected %0d, got %0d",
                               want.running_total, m_data.running_total);
                        mismatch_count++;
                    end
                    if (m_data.table_full_drop !== want.table_full_drop) begin
                        $error("table_full_drop: expected %0d, got %0d",
                               want.table_full_drop, m_data.table_full_drop);
                        mismatch_count++;
                    end
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 0);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // insert two keys, saturate a stored amount, update in place
    task automatic test_basic_entries();
        send_request(8'h00, 32'h0000_0001);
        send_request(8'hFF, 32'h7FFF_FFFF);
        send_request(8'hFF, 32'h7FFF_FFFF);
        send_request(8'h00, 32'h0000_0100);
    endtask

    // absent keys with zero and negative amounts, removal below and at zero
    task automatic test_removal();
        send_request(8'h33, 32'h0000_0000);
        send_request(8'h34, -32'sd5);
        send_request(8'hFF, 32'h8000_0000);
        send_request(8'h00, -32'sd257);
    endtask

    // equal amounts keep their order; a grown entry passes them, a shrunk one stays first
    task automatic test_tie_order();
        send_request(8'h11, 32'h0000_0040);
        send_request(8'h22, 32'h0000_0040);
        send_request(8'h44, 32'h0000_0040);
        send_request(8'h44, 32'h0000_0010);
        send_request(8'h44, -32'sd16);
    endtask

    // fill every slot, then a new positive key is refused and a negative one only moves the total
    task automatic test_table_full();
        for (int i = 0; i < 13; i++)
            send_request(KEY_W'(8'h80 + i), DELTA_W'((i + 1) * 16));
        send_request(8'hEE, 32'h0000_0001);
        send_request(8'hEE, -32'sd7);
    endtask

    // push the running total into its upper limit, then step back down from it
    task automatic test_total_limits();
        no_idle = 1'b1;
        repeat (260) send_request(8'h80, 32'h7FFF_FFFF);
        repeat (8) send_request(8'hEE, 32'h8000_0000);
        no_idle = 1'b0;
        wait_for_results();
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        skat_pkg::req_t req;
        long_hold_req = 1'b1;
        no_idle       = 1'b1;
        repeat (24) begin
            req = random_request();
            send_request(req.resource_id, req.delta_amount);
        end
        no_idle = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        skat_pkg::req_t req;
        for (int n = 0; n < 180; n++) begin
            // a stretch of back-to-back requests in the middle
            no_idle = (n >= 60 && n < 120);
            req = random_request();
            send_request(req.resource_id, req.delta_amount);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        tbl_used        = 0;
        tbl_total       = '0;
        mismatch_count  = 0;
        requests_sent   = 0;
        results_checked = 0;
        drops_seen      = 0;
        hit_total_max   = 1'b0;
        hit_total_min   = 1'b0;
        burst_left      = 0;
        no_idle         = 1'b0;
        long_hold_req   = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_entries();
        test_removal();
        test_tie_order();
        test_table_full();
        wait_for_results();
        test_total_limits();
        test_backpressure();
        test_random_traffic();

        wait_for_results();
        repeat (20) @(posedge aclk);

        $display("%0d requests applied, %0d results checked, %0d new keys refused when full",
                 requests_sent, results_checked, drops_seen);
        $display("running total held at its upper limit: %0b, at its lower limit: %0b",
                 hit_total_max, hit_total_min);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
